>>> src/sfpf_pkg.sv
// Shared types and constants for the sync-byte frame parser with Fletcher checksum.
// No dependencies; sfpf_core and sync_frame_parser_fletcher_unit import this package.
package sfpf_pkg;

  // Parser states, one code per expected byte of a frame.
  typedef enum logic [2:0] {
    ST_SYNC1   = 3'd0,
    ST_SYNC2   = 3'd1,
    ST_TYPE    = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_PAYLOAD = 3'd4,
    ST_CKA     = 3'd5,
    ST_CKB     = 3'd6
  } parse_state_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_e;

  // Largest frame type that is accepted.
  localparam logic [7:0] KindMax = 8'd2;

  // One result item.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] frame_kind;
    logic [7:0] frame_length;
    logic       frame_good;
    logic       frame_bad;
  } result_t;

endpackage

>>> src/sfpf_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
// Depends on nothing but plain logic types.
interface sfpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfpf_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [1:0] frame_kind;
  logic [7:0] frame_length;
  logic       frame_good;
  logic       frame_bad;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_kind, output frame_length, output frame_good, output frame_bad,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_kind, input frame_length, input frame_good, input frame_bad,
    output ready
  );
endinterface

>>> src/sfpf_core.sv
// Frame parser state machine and Fletcher checksum accumulator.
// Depends on sfpf_pkg; advances one byte per cycle when step_i is high.
module sfpf_core
  import sfpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] sync_first_i,
  input  logic [7:0] sync_second_i,
  output result_t    res_o
);

  parse_state_e state_q, state_d;
  logic [1:0]   kind_q, kind_d;
  logic [7:0]   len_q, len_d;
  logic [7:0]   idx_q, idx_d;
  logic [7:0]   sum_a_q, sum_a_d;
  logic [7:0]   sum_b_q, sum_b_d;
  logic [7:0]   acc_a, acc_b, idx_inc;

  // Running Fletcher sums and the next payload index.
  assign acc_a   = sum_a_q + byte_i;
  assign acc_b   = sum_b_q + acc_a;
  assign idx_inc = idx_q + 8'd1;

  // Next-state logic.
  always_comb begin
    state_d = ST_SYNC1;
    case (state_q)
      ST_SYNC1:   state_d = (byte_i == sync_first_i) ? ST_SYNC2 : ST_SYNC1;
      ST_SYNC2:   state_d = (byte_i == sync_second_i) ? ST_TYPE : ST_SYNC1;
      ST_TYPE:    state_d = (byte_i > KindMax) ? ST_SYNC1 : ST_LENGTH;
      ST_LENGTH:  state_d = ST_PAYLOAD;
      ST_PAYLOAD: state_d = (idx_inc >= len_q) ? ST_CKA : ST_PAYLOAD;
      ST_CKA:     state_d = (byte_i == sum_a_q) ? ST_CKB : ST_SYNC1;
      ST_CKB:     state_d = ST_SYNC1;
      default:    state_d = ST_SYNC1;
    endcase
  end

  // Datapath registers and the result of this byte.
  always_comb begin
    kind_d  = kind_q;
    len_d   = len_q;
    idx_d   = idx_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    res_o   = '0;
    // The checksum covers every byte after the two sync bytes and before the checksum fields.
    if (state_q == ST_SYNC1 || state_q == ST_SYNC2 || state_q == ST_TYPE ||
        state_q == ST_LENGTH || state_q == ST_PAYLOAD) begin
      sum_a_d = acc_a;
      sum_b_d = acc_b;
    end
    case (state_q)
      ST_SYNC2: begin
        if (byte_i == sync_second_i) begin
          sum_a_d = '0;
          sum_b_d = '0;
        end
      end
      ST_TYPE: begin
        if (byte_i <= KindMax) begin
          kind_d = byte_i[1:0];
        end
      end
      ST_LENGTH: begin
        len_d = byte_i;
        idx_d = '0;
      end
      ST_PAYLOAD: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = idx_q;
        idx_d               = idx_inc;
      end
      ST_CKA: begin
        res_o.frame_bad = (byte_i != sum_a_q);
      end
      ST_CKB: begin
        res_o.frame_good = (byte_i == sum_b_q);
        res_o.frame_bad  = (byte_i != sum_b_q);
      end
      default: begin
      end
    endcase
    res_o.frame_kind   = kind_d;
    res_o.frame_length = len_d;
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
      kind_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

endmodule

>>> src/sync_frame_parser_fletcher_unit.sv
// A byte passes through the input register and then the result register before its result is offered.
// Throughput: one byte per cycle; the parser state advances as a byte moves into the
// result register, so a stalled result holds one byte in the input register and then
// blocks further byte transfers until the result is taken.
// Reset (rst_ni, asynchronous, active low): parser waits for the first sync byte,
// sums, type, length and index clear, both sync registers read 0, no item is held.
module sync_frame_parser_fletcher_unit
  import sfpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  sfpf_in_if.sink    rx_i,
  sfpf_out_if.source res_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_res_q;
  result_t    core_res;
  logic [7:0] sync_first_q, sync_second_q;
  logic       advance;

  // A byte moves on when the result register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  sfpf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .res_o         (core_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.payload_valid = out_res_q.payload_valid;
  assign res_o.payload_byte  = out_res_q.payload_byte;
  assign res_o.payload_index = out_res_q.payload_index;
  assign res_o.frame_kind    = out_res_q.frame_kind;
  assign res_o.frame_length  = out_res_q.frame_length;
  assign res_o.frame_good    = out_res_q.frame_good;
  assign res_o.frame_bad     = out_res_q.frame_bad;

endmodule

>>> src/sfpf_checker.sv
// Port-level checks on the frame parser results, bound to the top level.
// Depends on sync_frame_parser_fletcher_unit and its result channel.
module sfpf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       payload_valid_i,
  input logic [7:0] payload_byte_i,
  input logic [7:0] payload_index_i,
  input logic [1:0] frame_kind_i,
  input logic       frame_good_i,
  input logic       frame_bad_i
);

  // A frame ends either good or bad, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(frame_good_i && frame_bad_i))
    else $error("frame reported good and bad at once");

  // A payload byte never carries a frame verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && payload_valid_i) |-> (!frame_good_i && !frame_bad_i))
    else $error("verdict raised on a payload byte");

  // Payload fields read zero outside the payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !payload_valid_i) |-> (payload_byte_i == 8'd0 && payload_index_i == 8'd0))
    else $error("payload fields set outside the payload");

  // Only accepted frame types are ever reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (frame_kind_i != 2'd3))
    else $error("frame kind out of range");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result withdrawn while stalled");

endmodule

bind sync_frame_parser_fletcher_unit sfpf_checker u_sfpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .payload_valid_i (res_o.payload_valid),
  .payload_byte_i  (res_o.payload_byte),
  .payload_index_i (res_o.payload_index),
  .frame_kind_i    (res_o.frame_kind),
  .frame_good_i    (res_o.frame_good),
  .frame_bad_i     (res_o.frame_bad)
);
